// ===== sv/postfix_stack_evaluator_top_macros.svh =====
// Assertion macros for the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every edge out of reset.
`define PSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pse assertion failed");
// Checked at every edge, reset included.
`define PSE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pse reset check failed");
`else
`define PSE_ASSERT(lbl, prop)
`define PSE_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/pse_pkg.sv =====
// Shared types and constants of the postfix stack evaluator.
`default_nettype none
package pse_pkg;

  localparam int WORD_W      = 32;
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STEP_W      = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] DIV_SENTINEL = WORD_W'(32'h4000_0000);

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_EOL  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_UNDER = 2'd1,
    FLT_OVER  = 2'd2
  } fault_t;

  typedef struct packed {
    logic              start;
    action_t           op;
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ===== sv/pse_alu.sv =====
// Serial arithmetic unit: bit-serial add/subtract, shift-add multiply, restoring divide.
`default_nettype none
module pse_alu
  import pse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_RUN  = 3'b010,
    A_FIX  = 3'b100
  } astate_t;

  astate_t           ast_r, ast_nxt;
  action_t           op_r, op_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic              carry_r, carry_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;

  logic              b_bit;
  logic              sum_bit;
  logic              carry_out;
  logic [WORD_W-1:0] mul_acc;
  logic [WORD_W:0]   trial;
  logic              fits;
  logic [WORD_W:0]   diff;

  always_comb begin
    b_bit     = (op_r == ACT_SUB) ? ~b_r[0] : b_r[0];
    sum_bit   = a_r[0] ^ b_bit ^ carry_r;
    carry_out = (a_r[0] & b_bit) | (a_r[0] & carry_r) | (b_bit & carry_r);
    mul_acc   = {acc_r[WORD_W-2:0], 1'b0} + (b_r[WORD_W-1] ? a_r : '0);
    trial     = {acc_r, a_r[WORD_W-1]};
    fits      = trial >= {1'b0, b_r};
    diff      = trial - {1'b0, b_r};
  end

  always_comb begin
    ast_nxt   = ast_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    neg_nxt   = neg_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    unique case (ast_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          step_nxt  = '0;
          acc_nxt   = '0;
          carry_nxt = (req.op == ACT_SUB);
          if (req.op == ACT_DIV) begin
            if (req.rhs == '0) begin
              // divide by zero: push the sentinel straight away
              res_nxt  = DIV_SENTINEL;
              done_nxt = 1'b1;
            end else begin
              a_nxt   = req.lhs[WORD_W-1] ? -req.lhs : req.lhs;
              b_nxt   = req.rhs[WORD_W-1] ? -req.rhs : req.rhs;
              neg_nxt = req.lhs[WORD_W-1] ^ req.rhs[WORD_W-1];
              ast_nxt = A_RUN;
            end
          end else begin
            a_nxt   = req.lhs;
            b_nxt   = req.rhs;
            ast_nxt = A_RUN;
          end
        end
      end
      A_RUN: begin
        if (op_r == ACT_DIV) begin
          // one quotient bit per cycle, quotient shifts into a_r
          acc_nxt = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
          a_nxt   = {a_r[WORD_W-2:0], fits};
        end else if (op_r == ACT_MUL) begin
          acc_nxt = mul_acc;
          b_nxt   = {b_r[WORD_W-2:0], 1'b0};
        end else begin
          acc_nxt   = {sum_bit, acc_r[WORD_W-1:1]};
          a_nxt     = {1'b0, a_r[WORD_W-1:1]};
          b_nxt     = {1'b0, b_r[WORD_W-1:1]};
          carry_nxt = carry_out;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(WORD_W - 1)) begin
          ast_nxt = A_FIX;
        end
      end
      A_FIX: begin
        if (op_r == ACT_DIV) begin
          res_nxt = neg_r ? -a_r : a_r;
        end else begin
          res_nxt = acc_r;
        end
        done_nxt = 1'b1;
        ast_nxt  = A_IDLE;
      end
      default: begin
        ast_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ast_r  <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      ast_r  <= ast_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
    neg_r   <= neg_nxt;
    step_r  <= step_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule
`default_nettype wire

// ===== sv/postfix_stack_evaluator_top.sv =====
// Sequence: a push is written when taken; an operator takes the word, reads the right and
//   left operands, starts the serial unit, runs 32 serial steps and a fix-up step (none for a
//   zero divisor) and writes back; end of line loads the top of stack into the output.
// Throughput: one word at a time; the 32-step serial loop of the arithmetic unit sets
//   the operator rate, the single read port of the stack memory the read sequence.
// Reset: synchronous, active low; empties the stack, clears the fault and the output.
`default_nettype none
`include "postfix_stack_evaluator_top_macros.svh"
module postfix_stack_evaluator_top
  import pse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand
  input  wire logic [2:0]  in_tuser,   // [2:0] action
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result_value
  output logic [2:0]       out_tuser   // [0] error_flag, [2:1] fault_code
);

  // Control sequencer: one-hot states.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,  // take a word
    S_RD_R   = 7'b0000010,  // read right operand
    S_RD_L   = 7'b0000100,  // latch right, read left operand
    S_START  = 7'b0001000,  // hand both operands to the serial unit
    S_EXEC   = 7'b0010000,  // wait for the unit, write back
    S_EOL_RD = 7'b0100000,  // read top of stack
    S_EOL    = 7'b1000000   // hold until the result register is free
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  fault_t            fault_r, fault_nxt;
  action_t           op_r, op_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [WORD_W-1:0] rdata_r;
  logic [WORD_W-1:0] rhs_r, rhs_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic              out_err_r, out_err_nxt;
  fault_t            out_fault_r, out_fault_nxt;

  // Stack storage: one write port, one registered read port.
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              in_accept;
  action_t           in_action;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] next_addr;
  fault_t            eol_fault;
  logic              eol_issue;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_action = action_t'(in_tuser);

  // Addresses of the top entry and the one beneath it.
  assign top_addr  = ADDR_W'(count_r - CNT_W'(1));
  assign next_addr = ADDR_W'(count_r - CNT_W'(2));

  // An empty stack at end of line is a fault unless an earlier one is held.
  assign eol_fault = (fault_r == FLT_NONE && count_r == '0) ? FLT_UNDER : fault_r;

  // Line result is loaded into the result register in this cycle.
  assign eol_issue = (state_r == S_EOL) && (state_nxt == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    fault_nxt     = fault_r;
    op_nxt        = op_r;
    rd_addr_nxt   = rd_addr_r;
    rhs_nxt       = rhs_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    out_fault_nxt = out_fault_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = in_tdata;
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    alu_req.lhs   = rdata_r;
    alu_req.rhs   = rhs_r;

    // Drop the result word once the sink takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_action)
            ACT_PUSH: begin
              if (count_r >= CNT_W'(STACK_DEPTH)) begin
                // full stack: drop the push, keep the first fault of the line
                if (fault_r == FLT_NONE) begin
                  fault_nxt = FLT_OVER;
                end
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
              if (count_r < CNT_W'(2)) begin
                if (fault_r == FLT_NONE) begin
                  fault_nxt = FLT_UNDER;
                end
              end else begin
                op_nxt      = in_action;
                rd_addr_nxt = top_addr;
                state_nxt   = S_RD_R;
              end
            end
            ACT_EOL: begin
              rd_addr_nxt = top_addr;
              state_nxt   = S_EOL_RD;
            end
            default: begin
              // undefined action codes: no effect
            end
          endcase
        end
      end
      S_RD_R: begin
        rd_addr_nxt = next_addr;
        state_nxt   = S_RD_L;
      end
      S_RD_L: begin
        rhs_nxt   = rdata_r;
        state_nxt = S_START;
      end
      S_START: begin
        alu_req.start = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          // pop two, push one: result lands where the left operand was
          wr_en     = 1'b1;
          wr_addr   = next_addr;
          wr_data   = alu_rsp.value;
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_EOL_RD: begin
        state_nxt = S_EOL;
      end
      S_EOL: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = eol_fault;
          out_value_nxt = (eol_fault == FLT_NONE) ? rdata_r : '0;
          out_err_nxt   = (eol_fault == FLT_NONE) && (rdata_r == DIV_SENTINEL);
          // clear the line
          count_nxt     = '0;
          fault_nxt     = FLT_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fault_r     <= FLT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rhs_r       <= rhs_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
    out_fault_r <= out_fault_nxt;
  end

  // Stack memory: write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rdata_r <= stack_mem[rd_addr_r];
  end

  pse_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_fault_r, out_err_r};

  // Checks.
  `PSE_ASSERT(a_count_bound, count_r <= CNT_W'(STACK_DEPTH))
  `PSE_ASSERT(a_alu_done_in_exec, alu_rsp.done |-> state_r == S_EXEC)
  `PSE_ASSERT(a_eol_clears, eol_issue |=> (count_r == '0 && fault_r == FLT_NONE && out_valid_r))
  `PSE_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r && count_r == '0))

endmodule
`default_nettype wire
